// ===== design/fan_curve_controller_with_alarm_defines.svh =====
// Assertion macros used by the checker file of the fan curve controller.
`ifndef FAN_CURVE_CONTROLLER_WITH_ALARM_DEFINES_SVH
`define FAN_CURVE_CONTROLLER_WITH_ALARM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fcc_pkg.sv =====
// Package with the widths, codes, reset values and shared types of the fan curve controller.
`default_nettype none

package fcc_pkg;

  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Width of (temperature span) * 100, the dividend of the curve division.
  localparam int unsigned SPD_DW = TEMP_W + PCT_W;

  localparam int unsigned DUTY_MAX_DEF    = 1023;
  localparam int unsigned BLINK_TICKS_DEF = 5;

  localparam logic [PCT_W-1:0]  PCT_FULL       = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_FIELD_MAX = 10'd1023;

  localparam logic                     MODE_AUTO          = 1'b0;
  localparam logic                     MODE_MANUAL        = 1'b1;
  localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RESET  = 16'sd400;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET     = 16'sd800;
  localparam logic [PCT_W-1:0]         MANUAL_PCT_RESET   = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL_MODE,
    REG_TARGET_TEMP,
    REG_MAX_TEMP,
    REG_MANUAL_PERCENT
  } cfg_reg_t;

  // One control tick handed to the LED blinker.
  typedef struct packed {
    logic step;
    logic alarm;
  } fcc_tick_t;

endpackage

`default_nettype wire

// ===== design/fcc_if.sv =====
// Valid/ready channel interfaces for the temperature requests and the fan results.
`default_nettype none

interface fcc_in_if import fcc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink (input valid, input temperature, output ready);
endinterface

interface fcc_out_if import fcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  speed_percent;
  logic [DUTY_W-1:0] pwm_duty;
  logic              over_temp_alarm;
  logic              alarm_led;

  modport source (output valid, output speed_percent, output pwm_duty,
                  output over_temp_alarm, output alarm_led, input ready);
  modport sink (input valid, input speed_percent, input pwm_duty,
                input over_temp_alarm, input alarm_led, output ready);
endinterface

`default_nettype wire

// ===== design/fcc_div.sv =====
// Restoring radix-2 divider that retires one quotient bit per cycle.
`default_nettype none

module fcc_div import fcc_pkg::*; #(
  parameter int unsigned DW = SPD_DW,
  parameter int unsigned VW = TEMP_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    work_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    div_r;

  logic [VW:0]   shifted;
  logic          fits;
  logic [VW:0]   diff;
  logic [VW-1:0] rem_nxt;

  // The partial remainder stays below the divisor, so the shifted value is
  // below twice the divisor and one subtraction settles each bit.
  always_comb begin
    shifted = {rem_r, work_r[DW-1]};
    fits    = shifted >= {1'b0, div_r};
    diff    = shifted - {1'b0, div_r};
    rem_nxt = fits ? diff[VW-1:0] : shifted[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // The dividend leaves at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      work_r <= {work_r[DW-2:0], fits};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

`default_nettype wire

// ===== design/fcc_blink.sv =====
// Alarm LED blinker that toggles the LED after a set number of alarm ticks and puts it out on a tick without the alarm.
`default_nettype none

module fcc_blink import fcc_pkg::*; #(
  parameter int unsigned BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fcc_tick_t tick,
  output logic           led
);

  localparam int unsigned CW = $clog2(BLINK_TICKS + 1);

  logic [CW-1:0] cnt_r;
  logic          led_r;
  logic [CW-1:0] cnt_inc;

  assign cnt_inc = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      led_r <= 1'b0;
    end else if (tick.step) begin
      if (tick.alarm) begin
        if (cnt_inc >= CW'(BLINK_TICKS)) begin
          cnt_r <= '0;
          led_r <= ~led_r;
        end else begin
          cnt_r <= cnt_inc;
        end
      end else begin
        cnt_r <= '0;
        led_r <= 1'b0;
      end
    end
  end

  assign led = led_r;

endmodule

`default_nettype wire

// ===== design/fan_curve_controller_with_alarm.sv =====
// Fan curve controller with over-temperature alarm: one result for every temperature request.
// A request is evaluated in ST_EVAL; in manual mode or when the curve is clamped it goes
// straight to the duty division, while on the linear part of the curve the curve division
// comes first. One request is handled at a time, paced by the bit-serial divider (DW bits,
// 23 with the default DUTY_MAX) used for the curve and for the duty. A new request is taken while a
// result still waits. Reset (synchronous, rst_n low) restores the defaults, LED off.
`default_nettype none

module fan_curve_controller_with_alarm import fcc_pkg::*; #(
  parameter int unsigned DUTY_MAX    = DUTY_MAX_DEF,
  parameter int unsigned BLINK_TICKS = BLINK_TICKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fcc_in_if.sink                     in_req,
  fcc_out_if.source                  out_res
);

  // The duty product speed * DUTY_MAX needs DUTY_PW bits; the divider is as wide as the
  // larger of the two dividends it ever sees.
  localparam int unsigned DUTY_PW = $clog2(100 * DUTY_MAX + 1);
  localparam int unsigned DW      = (DUTY_PW > SPD_DW) ? DUTY_PW : SPD_DW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SPD_GO,
    ST_SPD_DIV,
    ST_DUTY_GO,
    ST_DUTY_DIV,
    ST_HOLD
  } state_t;

  // Configuration registers. Write them only while the block is idle; the block does not enforce this.
  logic                     mode_r;
  logic signed [TEMP_W-1:0] target_r;
  logic signed [TEMP_W-1:0] max_r;
  logic [PCT_W-1:0]         manual_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_AUTO;
      target_r <= TARGET_TEMP_RESET;
      max_r    <= MAX_TEMP_RESET;
      manual_r <= MANUAL_PCT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONTROL_MODE:   mode_r   <= cfg_data[0];
        REG_TARGET_TEMP:    target_r <= cfg_data[TEMP_W-1:0];
        REG_MAX_TEMP:       max_r    <= cfg_data[TEMP_W-1:0];
        REG_MANUAL_PERCENT: manual_r <= cfg_data[PCT_W-1:0];
      endcase
    end
  end

  state_t                   state_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [TEMP_W-1:0]        num_r;
  logic [TEMP_W-1:0]        den_r;
  logic [PCT_W-1:0]         speed_r;
  logic [DUTY_W-1:0]        duty_r;
  logic                     alarm_r;

  logic                     out_valid_r;
  logic [PCT_W-1:0]         out_speed_r;
  logic [DUTY_W-1:0]        out_duty_r;
  logic                     out_alarm_r;
  logic                     out_led_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     alarm_now;
  logic [TEMP_W:0]          span_num;
  logic [TEMP_W:0]          span_den;
  logic [PCT_W-1:0]         manual_sat;
  logic [SPD_DW-1:0]        spd_prod;
  logic [DUTY_PW-1:0]       duty_prod;
  logic [DUTY_W-1:0]        duty_sat;
  fcc_tick_t                tick;
  logic                     led;

  logic                     div_start;
  logic [DW-1:0]            div_dividend;
  logic [TEMP_W-1:0]        div_divisor;
  logic                     div_done;
  logic [DW-1:0]            div_quot;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && (state_r == ST_IDLE);

  // The output register can take a new result when it is empty or is being emptied now.
  assign out_free = !out_valid_r || out_res.ready;

  // Temperature spans are formed one bit wider so that the sign never wraps; on the linear part
  // of the curve both spans are positive and fit in TEMP_W bits.
  assign span_num  = {temp_r[TEMP_W-1], temp_r} - {target_r[TEMP_W-1], target_r};
  assign span_den  = {max_r[TEMP_W-1], max_r} - {target_r[TEMP_W-1], target_r};
  assign alarm_now = temp_r > max_r;

  // A manual setting above full speed is clamped to full speed.
  assign manual_sat = (manual_r > PCT_FULL) ? PCT_FULL : manual_r;

  // Dividends: the span scaled to percent, and the percent scaled to the duty range.
  assign spd_prod  = SPD_DW'(num_r) * SPD_DW'(PCT_FULL);
  assign duty_prod = DUTY_PW'(speed_r) * DUTY_PW'(DUTY_MAX);

  // One divider serves both divisions: the curve by the temperature span, the duty by 100.
  assign div_start    = (state_r == ST_SPD_GO) || (state_r == ST_DUTY_GO);
  assign div_dividend = (state_r == ST_SPD_GO) ? DW'(spd_prod) : DW'(duty_prod);
  assign div_divisor  = (state_r == ST_SPD_GO) ? den_r : TEMP_W'(PCT_FULL);

  // A duty beyond the field saturates at the field's top value.
  assign duty_sat = (div_quot > DW'(DUTY_FIELD_MAX)) ? DUTY_FIELD_MAX : div_quot[DUTY_W-1:0];

  // The LED advances once per request, in the cycle the alarm is decided.
  assign tick.step  = (state_r == ST_EVAL);
  assign tick.alarm = alarm_now;

  fcc_div #(
    .DW (DW),
    .VW (TEMP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  fcc_blink #(
    .BLINK_TICKS (BLINK_TICKS)
  ) u_blink (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .led   (led)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In the hold state a taken result is replaced by the next one below.
      if (out_valid_r && out_res.ready && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            temp_r  <= in_req.temperature;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          alarm_r <= alarm_now;
          num_r   <= span_num[TEMP_W-1:0];
          den_r   <= span_den[TEMP_W-1:0];
          // Manual mode and the two flat ends of the curve need no curve division.
          priority if (mode_r == MODE_MANUAL) begin
            speed_r <= manual_sat;
            state_r <= ST_DUTY_GO;
          end else if (temp_r <= target_r) begin
            speed_r <= '0;
            state_r <= ST_DUTY_GO;
          end else if (temp_r >= max_r) begin
            speed_r <= PCT_FULL;
            state_r <= ST_DUTY_GO;
          end else begin
            state_r <= ST_SPD_GO;
          end
        end
        ST_SPD_GO: begin
          state_r <= ST_SPD_DIV;
        end
        ST_SPD_DIV: begin
          // Below the top of the curve the quotient is under 100 and fits the percent field.
          if (div_done) begin
            speed_r <= div_quot[PCT_W-1:0];
            state_r <= ST_DUTY_GO;
          end
        end
        ST_DUTY_GO: begin
          state_r <= ST_DUTY_DIV;
        end
        ST_DUTY_DIV: begin
          if (div_done) begin
            duty_r  <= duty_sat;
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_speed_r <= speed_r;
            out_duty_r  <= duty_r;
            out_alarm_r <= alarm_r;
            out_led_r   <= led;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.speed_percent   = out_speed_r;
  assign out_res.pwm_duty        = out_duty_r;
  assign out_res.over_temp_alarm = out_alarm_r;
  assign out_res.alarm_led       = out_led_r;

endmodule

`default_nettype wire

// ===== design/fcc_chk.sv =====
// Port-level checker for the fan curve controller, bound to the top level.
`default_nettype none
`include "fan_curve_controller_with_alarm_defines.svh"

module fcc_chk import fcc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PCT_W-1:0]  speed_percent,
  input wire logic [DUTY_W-1:0] pwm_duty,
  input wire logic              over_temp_alarm,
  input wire logic              alarm_led
);

  `FCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(speed_percent) && $stable(pwm_duty) && $stable(over_temp_alarm) && $stable(alarm_led), "stalled result changed")
  `FCC_ASSERT_NOW(a_led_off, out_valid && !over_temp_alarm, !alarm_led, "LED lit without alarm")
  `FCC_ASSERT_NOW(a_speed_range, out_valid, speed_percent <= PCT_FULL, "speed above full")
  `FCC_ASSERT_NOW(a_zero_duty, out_valid && (speed_percent == '0), pwm_duty == '0, "duty without speed")

endmodule

bind fan_curve_controller_with_alarm fcc_chk u_fcc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .speed_percent   (out_res.speed_percent),
  .pwm_duty        (out_res.pwm_duty),
  .over_temp_alarm (out_res.over_temp_alarm),
  .alarm_led       (out_res.alarm_led)
);

`default_nettype wire

// ===== bench/fan_curve_controller_with_alarm_tb.sv =====
// Self-checking testbench for the fan curve controller with over-temperature alarm.
`default_nettype none

module fan_curve_controller_with_alarm_tb;
  import fcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result as the controller should produce it, with the temperature kept for messages.
  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [PCT_W-1:0]         speed;
    logic [DUTY_W-1:0]        duty;
    logic                     alarm;
    logic                     led;
  } fan_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fcc_in_if  in_ch();
  fcc_out_if out_ch();

  fan_curve_controller_with_alarm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_ch),
    .out_res   (out_ch)
  );

  // Temperatures waiting to be offered, and the results that accepted requests still owe us.
  logic signed [TEMP_W-1:0] pending_temps[$];
  fan_result_t              expected_results[$];

  // Our own copy of the register file, updated as each write lands.
  logic             cur_mode   = MODE_AUTO;
  int               cur_target = 400;
  int               cur_max    = 800;
  logic [PCT_W-1:0] cur_manual = '0;

  // Blink state of the alarm LED as the predictor sees it.
  int   blink_ticks = 0;
  logic led_lit     = 1'b0;

  int errors        = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int alarm_count   = 0;
  int led_on_count  = 0;
  int setting_count = 0;
  int cycle_count   = 0;

  // Sender burst shaping.
  int burst_left = 0;
  int gap_left   = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Works out the speed, duty, alarm and LED level for one tick and advances the blink state.
  function automatic fan_result_t predict_fan_tick(input logic signed [TEMP_W-1:0] temp);
    fan_result_t r;
    int t;
    int speed;
    int duty;
    t = temp;
    if (cur_mode == MODE_AUTO) begin
      if (t <= cur_target) begin
        speed = 0;
      end else if (t >= cur_max) begin
        speed = 100;
      end else begin
        // Here cur_max > t > cur_target, so the span is positive and the product fits in int.
        speed = ((t - cur_target) * 100) / (cur_max - cur_target);
      end
    end else begin
      speed = cur_manual;
    end
    if (speed > 100) speed = 100;
    duty = (speed * int'(DUTY_MAX_DEF)) / 100;
    if (duty > 1023) duty = 1023;
    r.alarm = (t > cur_max);
    if (r.alarm) begin
      blink_ticks++;
      if (blink_ticks >= int'(BLINK_TICKS_DEF)) begin
        blink_ticks = 0;
        led_lit = ~led_lit;
      end
    end else begin
      // The LED goes dark and the blink count restarts on the tick the alarm clears.
      blink_ticks = 0;
      led_lit = 1'b0;
    end
    r.temp  = temp;
    r.speed = speed[PCT_W-1:0];
    r.duty  = duty[DUTY_W-1:0];
    r.led   = led_lit;
    return r;
  endfunction

  // A temperature that lands mostly around the current curve, sometimes on its edges,
  // and sometimes anywhere in the 16-bit range.
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int lo;
    int hi;
    int quarter;
    int t;
    lo = (cur_target < cur_max) ? cur_target : cur_max;
    hi = (cur_target < cur_max) ? cur_max : cur_target;
    quarter = (hi - lo) / 4 + 8;
    lo = lo - quarter;
    hi = hi + quarter;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    case ($urandom_range(0, 9))
      0, 1: t = $signed(16'($urandom));
      2: begin
        case ($urandom_range(0, 5))
          0: t = cur_target - 1;
          1: t = cur_target;
          2: t = cur_target + 1;
          3: t = cur_max - 1;
          4: t = cur_max;
          default: t = cur_max + 1;
        endcase
      end
      default: t = lo + int'($urandom_range(0, hi - lo));
    endcase
    if (t < -32768) t = -32768;
    if (t > 32767) t = 32767;
    return t[TEMP_W-1:0];
  endfunction

  // Sender: offers queued temperatures in bursts with random gaps and holds each request
  // until the block takes it. The prediction is made at the edge of acceptance, so it
  // always sees the register values the block itself used.
  always @(posedge clk) begin : sender
    logic fire;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.temperature <= '0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        expected_results.push_back(predict_fan_tick(in_ch.temperature));
        sent_count++;
      end
      if (!in_ch.valid || fire) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            // Long bursts with no gap chain together into stretches without idling.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
          end
        end
        if (burst_left != 0 && pending_temps.size() != 0) begin
          in_ch.valid       <= 1'b1;
          in_ch.temperature <= pending_temps.pop_front();
          burst_left--;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a pattern that steps through four styles in turn and checks
  // each accepted result against the oldest outstanding request.
  always @(posedge clk) begin : receiver
    fan_result_t want;
    logic        take;
    cycle_count++;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: speed %0d duty %0d alarm %0b led %0b",
                   $time, out_ch.speed_percent, out_ch.pwm_duty, out_ch.over_temp_alarm,
                   out_ch.alarm_led);
          errors++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (want.alarm) alarm_count++;
          if (want.led) led_on_count++;
          if (out_ch.speed_percent !== want.speed) begin
            $display("%0t: temp %0d speed_percent expected %0d actual %0d",
                     $time, want.temp, want.speed, out_ch.speed_percent);
            errors++;
          end
          if (out_ch.pwm_duty !== want.duty) begin
            $display("%0t: temp %0d pwm_duty expected %0d actual %0d",
                     $time, want.temp, want.duty, out_ch.pwm_duty);
            errors++;
          end
          if (out_ch.over_temp_alarm !== want.alarm) begin
            $display("%0t: temp %0d over_temp_alarm expected %0b actual %0b",
                     $time, want.temp, want.alarm, out_ch.over_temp_alarm);
            errors++;
          end
          if (out_ch.alarm_led !== want.led) begin
            $display("%0t: temp %0d alarm_led expected %0b actual %0b",
                     $time, want.temp, want.led, out_ch.alarm_led);
            errors++;
          end
        end
      end
      case ((cycle_count / 700) % 4)
        0: take = 1'b1;                                // always ready
        1: take = ($urandom_range(0, 3) != 0);         // light random stalls
        2: take = ($urandom_range(0, 7) == 0);         // heavy random stalls
        default: take = ((cycle_count % 97) > 60);     // long fixed stall windows
      endcase
      out_ch.ready <= take;
    end
  end

  // One register write; the mirror follows it once the write has landed.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CONTROL_MODE:   cur_mode   = data[0];
      REG_TARGET_TEMP:    cur_target = $signed(data);
      REG_MAX_TEMP:       cur_max    = $signed(data);
      REG_MANUAL_PERCENT: cur_manual = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all four registers. The mode and percent writes carry random junk in the
  // unused upper bits, which the block must ignore.
  task automatic apply_settings(input logic mode, input int target, input int ceiling,
                                input int pct);
    write_reg(REG_CONTROL_MODE, {15'($urandom), mode});
    write_reg(REG_TARGET_TEMP, 16'(target));
    write_reg(REG_MAX_TEMP, 16'(ceiling));
    write_reg(REG_MANUAL_PERCENT, {9'($urandom), 7'(pct)});
    setting_count++;
  endtask

  // Returns once the sender has nothing left to offer and every request has its result.
  // Sampled on the falling edge so that all updates of the rising edge have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_temps.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Queues a random batch: mostly scattered ticks around the curve, with runs of
  // consecutive over-temperature ticks so the LED gets to blink and then clear.
  task automatic queue_random_ticks(input int count);
    int queued;
    int run_len;
    int headroom;
    queued = 0;
    while (queued < count) begin
      if (cur_max < 32767 && $urandom_range(0, 7) == 0) begin
        run_len  = $urandom_range(3, 14);
        headroom = 32766 - cur_max;
        if (headroom > 300) headroom = 300;
        repeat (run_len) begin
          pending_temps.push_back(16'(cur_max + 1 + int'($urandom_range(0, headroom))));
          queued++;
        end
      end else begin
        pending_temps.push_back(pick_temp());
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    int target;
    int ceiling;
    in_ch.valid       = 1'b0;
    in_ch.temperature = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_CONTROL_MODE;
    cfg_data          = '0;
    rst_n             = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: both field extremes, each edge of the curve, the middle of it,
    // and an alarm that clears. Then a run long enough for the LED to toggle on, and
    // a cool tick that must put it out again.
    pending_temps = '{-32768, 32767, 400, 401, 600, 799, 800, 801, -1, 0,
                      900, 900, 900, 900, 900, 900, 900, 500};
    wait_drained();

    // Manual mode with a percent above 100, which must saturate to full speed.
    apply_settings(MODE_MANUAL, 400, 800, 127);
    pending_temps = '{0, 1000};
    wait_drained();

    // Target above max: anything over the target is also past the max. Then target
    // equal to max.
    apply_settings(MODE_AUTO, 32767, -32768, 0);
    pending_temps = '{-32768, 0, 32767};
    wait_drained();
    apply_settings(MODE_AUTO, 800, 800, 0);
    pending_temps = '{801};
    wait_drained();

    // Widest span the registers allow.
    apply_settings(MODE_AUTO, -32768, 32767, 0);
    pending_temps = '{32766, 0};
    wait_drained();

    // Random part. Each phase picks a setting and then waits for every result, so the
    // sender also sits idle until the block has fully drained.
    for (int phase = 0; phase < 12; phase++) begin
      target = int'($urandom_range(0, 65535)) - 32768;
      case (phase % 6)
        0: apply_settings(MODE_AUTO, 400, 800, $urandom_range(0, 127));
        1: begin
          ceiling = target + int'($urandom_range(1, 3000));
          if (ceiling > 32767) ceiling = 32767;
          apply_settings(MODE_AUTO, target, ceiling, $urandom_range(0, 127));
        end
        2: begin
          ceiling = int'($urandom_range(0, 65535)) - 32768;
          apply_settings(MODE_MANUAL, target, ceiling, $urandom_range(0, 127));
        end
        3: begin
          ceiling = target - int'($urandom_range(0, 500));
          if (ceiling < -32768) ceiling = -32768;
          apply_settings(MODE_AUTO, target, ceiling, $urandom_range(0, 127));
        end
        4: apply_settings(MODE_AUTO, -32768, 32767, $urandom_range(0, 127));
        default: begin
          // A span of one or two steps exercises the smallest divisors.
          ceiling = target + int'($urandom_range(1, 2));
          if (ceiling > 32767) ceiling = 32767;
          apply_settings(MODE_AUTO, target, ceiling, $urandom_range(0, 127));
        end
      endcase
      queue_random_ticks(75);
      wait_drained();
    end

    // Give any stray result time to show up before the verdict.
    repeat (120) @(posedge clk);

    $display("Ran %0d temperature requests over %0d register settings; %0d results checked.",
             sent_count, setting_count, checked_count);
    $display("%0d results carried the over-temperature alarm and %0d had the LED lit.",
             alarm_count, led_on_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #8ms;
    $display("Timed out with %0d requests still queued and %0d results outstanding.",
             pending_temps.size(), expected_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
